>>> rtl/core/fbfill_pkg.sv
// Shared types, constants and helper functions for the rectangle fill engine.
// Used by every module under rtl/core; depends on nothing else.
package fbfill_pkg;

  // Display geometry and frame store size.
  localparam int DISP_W = 240;
  localparam int DISP_H = 160;
  localparam int DEPTH  = DISP_W * DISP_H;
  localparam int AW     = $clog2(DEPTH);

  // Clipped coordinates run from 0 up to and including the display size.
  localparam int XW = $clog2(DISP_W + 1);
  localparam int YW = $clog2(DISP_H + 1);

  // Signed working width for coordinate sums (16-bit inputs plus carries).
  localparam int SW = 19;
  typedef logic signed [SW-1:0] sval_t;

  // Depth of the command queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Command codes of the func field; the last code is unassigned and ignored.
  typedef enum logic [2:0] {
    CMD_PIXEL   = 3'd0,
    CMD_HLINE   = 3'd1,
    CMD_VLINE   = 3'd2,
    CMD_OUTLINE = 3'd3,
    CMD_FILL    = 3'd4,
    CMD_SCREEN  = 3'd5,
    CMD_READ    = 3'd6,
    CMD_UNUSED  = 3'd7
  } cmd_e;

  // Kinds of queued operation.
  typedef enum logic {
    OP_BOX  = 1'b0,
    OP_READ = 1'b1
  } op_kind_e;

  // One clipped operation handed from the front to the back.
  typedef struct packed {
    op_kind_e        kind;
    logic            off;
    logic [XW-1:0]   x0;
    logic [XW-1:0]   x1;
    logic [YW-1:0]   y0;
    logic [YW-1:0]   y1;
    logic [7:0]      colour;
  } op_t;

  // Clamp a signed coordinate to the range 0 .. DISP_W.
  function automatic logic [XW-1:0] clamp_x(sval_t v);
    priority if (v < 0) begin
      return '0;
    end else if (v > sval_t'(DISP_W)) begin
      return XW'(DISP_W);
    end else begin
      return v[XW-1:0];
    end
  endfunction

  // Clamp a signed coordinate to the range 0 .. DISP_H.
  function automatic logic [YW-1:0] clamp_y(sval_t v);
    priority if (v < 0) begin
      return '0;
    end else if (v > sval_t'(DISP_H)) begin
      return YW'(DISP_H);
    end else begin
      return v[YW-1:0];
    end
  endfunction

  // RGB332 to RGB565 expansion.
  function automatic logic [15:0] to_wide(logic [7:0] p);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    unique case (p[7:5])
      3'd0: r = 5'd0;
      3'd1: r = 5'd4;
      3'd2: r = 5'd9;
      3'd3: r = 5'd13;
      3'd4: r = 5'd18;
      3'd5: r = 5'd22;
      3'd6: r = 5'd27;
      3'd7: r = 5'd31;
      default: r = 5'd0;
    endcase
    // Green times nine is the 3-bit value repeated.
    g = {p[4:2], p[4:2]};
    unique case (p[1:0])
      2'd0: b = 5'd0;
      2'd1: b = 5'd10;
      2'd2: b = 5'd21;
      2'd3: b = 5'd31;
      default: b = 5'd0;
    endcase
    return {r, g, b};
  endfunction

endpackage

>>> rtl/core/fbfill_front.sv
// Command front end: accepts drawing and read commands, splits outlines into
// boxes, clips each box to the display and queues it. Depends on fbfill_pkg.
module fbfill_front import fbfill_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        hold,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  func,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [15:0] span_w,
  input  logic [15:0] span_h,
  input  logic [7:0]  colour,
  output logic        q_push,
  output op_t         q_data,
  input  logic        q_full
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GEN,
    ST_CLIP
  } state_t;

  state_t      state;
  logic [2:0]  func_q;
  sval_t       cx, cy, cw, ch;
  logic [7:0]  col_q;
  logic [1:0]  sub;
  logic [1:0]  last_sub;
  logic        skip;

  // Box of the current sub-step before clipping.
  sval_t       bx, by, bw, bh;
  op_kind_e    bkind;
  logic        blive;

  // Raw box for the current command and sub-step.
  sval_t       gx, gy, gw, gh;
  op_kind_e    gkind;

  always_comb begin
    gx    = cx;
    gy    = cy;
    gw    = sval_t'(1);
    gh    = sval_t'(1);
    gkind = OP_BOX;
    unique case (cmd_e'(func_q))
      CMD_PIXEL: ;
      CMD_HLINE: gw = cw;
      CMD_VLINE: gh = ch;
      CMD_OUTLINE: begin
        unique case (sub)
          2'd0: gw = cw;
          2'd1: begin
            gy = cy + ch - sval_t'(1);
            gw = cw;
          end
          2'd2: begin
            gy = cy + sval_t'(1);
            gh = ch - sval_t'(2);
          end
          2'd3: begin
            gx = cx + cw - sval_t'(1);
            gy = cy + sval_t'(1);
            gh = ch - sval_t'(2);
          end
          default: ;
        endcase
      end
      CMD_FILL: begin
        gw = cw;
        gh = ch;
      end
      CMD_SCREEN: begin
        gx = '0;
        gy = '0;
        gw = sval_t'(DISP_W);
        gh = sval_t'(DISP_H);
      end
      CMD_READ: gkind = OP_READ;
      default: ;
    endcase
  end

  // Clipping of the staged box.
  logic [XW-1:0] x0c, x1c;
  logic [YW-1:0] y0c, y1c;
  logic          box_empty;
  logic          off;
  logic          need_push;

  always_comb begin
    x0c       = clamp_x(bx);
    x1c       = clamp_x(bx + bw);
    y0c       = clamp_y(by);
    y1c       = clamp_y(by + bh);
    box_empty = (bw < sval_t'(1)) || (bh < sval_t'(1)) || (x1c <= x0c) || (y1c <= y0c);
    off       = (bx < 0) || (bx >= sval_t'(DISP_W)) || (by < 0) || (by >= sval_t'(DISP_H));
    need_push = blive && ((bkind == OP_READ) || !box_empty);
    q_data.kind   = bkind;
    q_data.off    = off;
    q_data.x0     = x0c;
    q_data.x1     = x1c;
    q_data.y0     = y0c;
    q_data.y1     = y1c;
    q_data.colour = col_q;
  end

  assign q_push = (state == ST_CLIP) && need_push && !q_full;
  assign full   = (state != ST_IDLE) || hold;

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (push && !full) begin
            func_q <= func;
            cx     <= sval_t'($signed(pos_x));
            cy     <= sval_t'($signed(pos_y));
            cw     <= sval_t'($signed(span_w));
            ch     <= sval_t'($signed(span_h));
            col_q  <= colour;
            sub    <= '0;
            // An outline has four boxes; it draws nothing unless both spans are positive.
            last_sub <= (cmd_e'(func) == CMD_OUTLINE) ? 2'd3 : 2'd0;
            skip     <= (cmd_e'(func) == CMD_UNUSED) ||
                        ((cmd_e'(func) == CMD_OUTLINE) &&
                         (($signed(span_w) < 16'sd1) || ($signed(span_h) < 16'sd1)));
            state  <= ST_GEN;
          end
        end
        ST_GEN: begin
          bx    <= gx;
          by    <= gy;
          bw    <= gw;
          bh    <= gh;
          bkind <= gkind;
          blive <= !skip;
          state <= ST_CLIP;
        end
        ST_CLIP: begin
          if (!need_push || !q_full) begin
            if (sub == last_sub) begin
              state <= ST_IDLE;
            end else begin
              sub   <= sub + 2'd1;
              state <= ST_GEN;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/fbfill_queue.sv
// Short first-in first-out queue of clipped operations between front and back.
// Depends on fbfill_pkg for the operation type and queue depth.
module fbfill_queue import fbfill_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  op_t  wr_data,
  output logic full,
  input  logic rd_en,
  output op_t  rd_data,
  output logic empty
);

  op_t            entries [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  assign full    = (count == QCW'(QDEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  // Storage, written at the tail.
  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en && !empty) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr_en && !full, rd_en && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/fbfill_back.sv
// Drawing back end: owns the frame store, clears it after reset, fills clipped
// boxes one pixel per cycle and answers reads. Depends on fbfill_pkg.
module fbfill_back import fbfill_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  output logic        clearing,
  input  op_t         q_head,
  input  logic        q_empty,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  pixel_raw,
  output logic [15:0] pixel_wide,
  output logic        off_screen
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_FILL,
    ST_RDMEM,
    ST_RESP
  } state_t;

  state_t         state;
  op_t            op;
  logic [AW-1:0]  clr_addr;
  logic [AW-1:0]  addr;
  logic [AW-1:0]  row_start;
  logic [XW-1:0]  cx;
  logic [YW-1:0]  cy;
  logic           out_valid;
  logic [7:0]     out_raw;
  logic [15:0]    out_wide;
  logic           out_off;
  logic           res_load;

  logic [7:0]     frame_store [DEPTH];
  logic [7:0]     rd_q;
  logic           we;
  logic [AW-1:0]  waddr;
  logic [7:0]     wdata;
  logic [AW-1:0]  base;

  assign clearing   = (state == ST_CLEAR);
  assign q_pop      = (state == ST_IDLE) && !q_empty;
  assign empty      = !out_valid;
  assign pixel_raw  = out_raw;
  assign pixel_wide = out_wide;
  assign off_screen = out_off;

  // A read result enters the result register once the previous word has gone.
  assign res_load = (state == ST_RESP) && (!out_valid || pop);

  // Write port: zeros during the clearing pass, the colour during a fill.
  assign we    = (state == ST_CLEAR) || (state == ST_FILL);
  assign waddr = (state == ST_CLEAR) ? clr_addr : addr;
  assign wdata = (state == ST_CLEAR) ? 8'd0 : op.colour;

  // Start address of the first row of the operation.
  assign base = AW'(32'(op.y0) * DISP_W) + AW'(op.x0);

  // Frame store with a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      frame_store[waddr] <= wdata;
    end
    rd_q <= frame_store[addr];
  end

  // Operation sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // The result register fills on a response and drains on a pop.
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (!q_empty) begin
            op    <= q_head;
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          addr      <= base;
          row_start <= base;
          cx        <= op.x0;
          cy        <= op.y0;
          priority if (op.kind == OP_BOX) begin
            state <= ST_FILL;
          end else if (op.off) begin
            state <= ST_RESP;
          end else begin
            state <= ST_RDMEM;
          end
        end
        ST_FILL: begin
          // Walk the box row by row, one pixel per cycle.
          if (cx == op.x1 - 1'b1) begin
            if (cy == op.y1 - 1'b1) begin
              state <= ST_IDLE;
            end else begin
              cy        <= cy + 1'b1;
              cx        <= op.x0;
              row_start <= row_start + AW'(DISP_W);
              addr      <= row_start + AW'(DISP_W);
            end
          end else begin
            cx   <= cx + 1'b1;
            addr <= addr + 1'b1;
          end
        end
        ST_RDMEM: begin
          state <= ST_RESP;
        end
        ST_RESP: begin
          // Load the result word once the previous one has gone.
          if (res_load) begin
            out_off   <= op.off;
            out_raw   <= op.off ? 8'd0 : rd_q;
            out_wide  <= op.off ? 16'd0 : to_wide(rd_q);
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // No result word appears while the store is being cleared.
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !out_valid)
    else $error("result word present during clearing pass");

  // The fill walk stays inside the clipped box.
  a_fill_in_box: assert property (@(posedge clk) disable iff (rst)
    state == ST_FILL |-> (cx >= op.x0) && (cx < op.x1) && (cy >= op.y0) && (cy < op.y1))
    else $error("fill position outside its box");

  // Fill addresses stay within the frame store.
  a_fill_addr: assert property (@(posedge clk) disable iff (rst)
    state == ST_FILL |-> {1'b0, addr} < (AW + 1)'(DEPTH))
    else $error("fill address beyond frame store");

  // An off-screen read carries zero data.
  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_off |-> (out_raw == 8'd0) && (out_wide == 16'd0))
    else $error("off-screen read with nonzero data");

endmodule

>>> rtl/core/framebuffer_rect_fill_engine_top.sv
// Top level of the clipped rectangle fill engine over an RGB332 frame store.
// Instantiates fbfill_front, fbfill_queue and fbfill_back; uses fbfill_pkg.
//
// Usage:
//   Commands enter through a queue-style port: a word is taken at a clock edge
//   where push is high and full is low. Draw commands (pixel, lines, outline,
//   filled box, screen fill) give no result; a read gives one result word on
//   pixel_raw, pixel_wide and off_screen, valid while empty is low and taken
//   when pop is high.
//   The front end takes a command in its idle state and then passes each box
//   through a generate state and a clip state (four boxes for an outline, one
//   for everything else); full stays high until the last box is done, and a
//   box to be queued waits in the clip state while the queue is full. Boxes
//   wait in a four-entry queue for the back end, which writes one clipped
//   pixel per clock. A read passes the back end's setup state, a memory read
//   state (skipped when off screen) and a response state before it shows.
//   After reset the back end clears the store one pixel per cycle, and full
//   stays high until the pass ends.
//   A result word that is not popped holds the back end at the next read only;
//   draws behind it go on, and commands keep flowing until the queue fills.
module framebuffer_rect_fill_engine_top import fbfill_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  func,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [15:0] span_w,
  input  logic [15:0] span_h,
  input  logic [7:0]  colour,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  pixel_raw,
  output logic [15:0] pixel_wide,
  output logic        off_screen
);

  logic clearing;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  op_t  q_in;
  op_t  q_head;

  // Command intake and clipping.
  fbfill_front u_front (
    .clk    (clk),
    .rst    (rst),
    .hold   (clearing),
    .push   (push),
    .full   (full),
    .func   (func),
    .pos_x  (pos_x),
    .pos_y  (pos_y),
    .span_w (span_w),
    .span_h (span_h),
    .colour (colour),
    .q_push (q_push),
    .q_data (q_in),
    .q_full (q_full)
  );

  // Operation queue.
  fbfill_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_in),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  // Frame store and pixel engine.
  fbfill_back u_back (
    .clk        (clk),
    .rst        (rst),
    .clearing   (clearing),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .pixel_raw  (pixel_raw),
    .pixel_wide (pixel_wide),
    .off_screen (off_screen)
  );

endmodule
